// ----- hdl/deq_pkg.sv -----
`default_nettype none
package deq_pkg;

	localparam int DEQ_DEPTH = 16;
	localparam int DATA_W    = 32;
	localparam int ACT_W     = 3;
	localparam int STAT_W    = 2;

	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_LIST       = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage
`default_nettype wire

// ----- hdl/deq_ram.sv -----
`default_nettype none
module deq_ram
	import deq_pkg::*;
#(
	parameter int DEPTH = DEQ_DEPTH,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/double_ended_queue_unit.sv -----
// Bounded double-ended queue of signed 32-bit values held in a single-port-read
// circular memory of DEPTH entries. The action arrives in s_tuser; a push answers
// with one status item in the cycle after it is taken, a pop answers with the
// removed value (or an empty status), and a list streams every stored value from
// front to rear with tlast on the final one (or an empty status). Unused action
// codes are taken but answer with no item. A pop that returns data passes through
// the registered memory read, and a list does one memory read per entry. A new
// item is not taken while a pop or list is still reading, nor while a finished
// result waits in the output register unless that result leaves in the same
// cycle, so a stalled output holds off the input. Memory contents are undefined
// after reset; only entries written by a push are ever read.
`default_nettype none
module double_ended_queue_unit
	import deq_pkg::*;
#(
	parameter int DEPTH = DEQ_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [DATA_W-1:0] s_tdata,   // value_in
	input  wire logic [ACT_W-1:0]  s_tuser,   // action
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [DATA_W-1:0] m_tdata,   // value_out
	output logic      [STAT_W-1:0] m_tuser,   // status
	output logic                   m_tlast
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic {S_IDLE, S_DATA} state_t;

	state_t            state_q;
	logic [PTR_W-1:0]  front_q;
	logic [CNT_W-1:0]  occ_q;
	logic [PTR_W-1:0]  idx_q;
	logic              pop_q;
	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_tdata_q;
	logic [STAT_W-1:0] m_tuser_q;
	logic              m_tlast_q;

	logic              out_free;
	logic              accept;
	logic              is_empty;
	logic              is_full;
	logic [PTR_W-1:0]  occ_ptr;
	logic [PTR_W-1:0]  front_dec;
	logic [PTR_W-1:0]  front_inc;
	logic [PTR_W-1:0]  rear_slot;
	logic [PTR_W-1:0]  rear_last;
	logic [PTR_W-1:0]  idx_next;
	logic              data_last;

	logic              wr_en;
	logic [PTR_W-1:0]  wr_addr;
	logic              rd_en;
	logic [PTR_W-1:0]  rd_addr;
	logic [DATA_W-1:0] rd_data;

	function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
			input logic [PTR_W-1:0] b);
		logic [PTR_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (PTR_W+1)'(DEPTH)) begin
			s = s - (PTR_W+1)'(DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && out_free;
	assign accept    = s_tvalid && s_tready;
	assign is_empty  = (occ_q == '0);
	assign is_full   = (occ_q == CNT_W'(DEPTH));
	assign occ_ptr   = occ_q[PTR_W-1:0];
	assign front_dec = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = wrap_add(front_q, PTR_W'(1));
	assign rear_slot = wrap_add(front_q, occ_ptr);
	assign rear_last = wrap_add(front_q, occ_ptr - 1'b1);
	assign idx_next  = idx_q + 1'b1;
	assign data_last = pop_q || ((CNT_W'(idx_q) + CNT_W'(1)) == occ_q);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rear_slot;
		rd_en   = 1'b0;
		rd_addr = front_q;
		if (accept) begin
			unique case (s_tuser)
				ACT_PUSH_FRONT: begin
					wr_en   = !is_full;
					wr_addr = front_dec;
				end
				ACT_PUSH_REAR: begin
					wr_en   = !is_full;
					wr_addr = rear_slot;
				end
				ACT_POP_FRONT, ACT_LIST: begin
					rd_en   = !is_empty;
					rd_addr = front_q;
				end
				ACT_POP_REAR: begin
					rd_en   = !is_empty;
					rd_addr = rear_last;
				end
				default: begin
				end
			endcase
		end else if (state_q == S_DATA && out_free && !data_last) begin
			rd_en   = 1'b1;
			rd_addr = wrap_add(front_q, idx_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			front_q    <= '0;
			occ_q      <= '0;
			idx_q      <= '0;
			pop_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= STAT_OK;
			m_tlast_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (s_tuser)
							ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
								m_tvalid_q <= 1'b1;
								m_tdata_q  <= '0;
								m_tlast_q  <= 1'b1;
								if (is_full) begin
									m_tuser_q <= STAT_FULL;
								end else begin
									m_tuser_q <= STAT_OK;
									occ_q     <= occ_q + 1'b1;
									if (s_tuser == ACT_PUSH_FRONT) begin
										front_q <= front_dec;
									end
								end
							end
							ACT_POP_FRONT, ACT_POP_REAR, ACT_LIST: begin
								if (is_empty) begin
									m_tvalid_q <= 1'b1;
									m_tdata_q  <= '0;
									m_tuser_q  <= STAT_EMPTY;
									m_tlast_q  <= 1'b1;
								end else begin
									state_q <= S_DATA;
									idx_q   <= '0;
									pop_q   <= (s_tuser != ACT_LIST);
									if (s_tuser != ACT_LIST) begin
										occ_q <= occ_q - 1'b1;
									end
									if (s_tuser == ACT_POP_FRONT) begin
										front_q <= front_inc;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DATA: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= rd_data;
						m_tuser_q  <= STAT_OK;
						m_tlast_q  <= data_last;
						if (data_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_next;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	deq_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (PTR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (s_tdata),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule
`default_nettype wire

// ----- hdl/deq_chk.sv -----
`default_nettype none
module deq_chk
	import deq_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_tvalid,
	input wire logic              s_tready,
	input wire logic [ACT_W-1:0]  s_tuser,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [DATA_W-1:0] m_tdata,
	input wire logic [STAT_W-1:0] m_tuser,
	input wire logic              m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("Stalled result item changed.");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STAT_OK |-> m_tdata == '0 && m_tlast)
		else $error("Status-only item carries data or is not last.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == STAT_OK || m_tuser == STAT_EMPTY || m_tuser == STAT_FULL)
		else $error("Undefined status code.");

	a_push_answer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ACT_PUSH_FRONT || s_tuser == ACT_PUSH_REAR)
			|=> m_tvalid && m_tlast && m_tdata == '0)
		else $error("Push item did not answer in the next cycle.");

endmodule

bind double_ended_queue_unit deq_chk u_deq_chk (.*);
`default_nettype wire
